// ===== rtl/lhsc_pkg.sv =====
// Shared types, constants and saturation helpers for the lambda sensor converter.
package lhsc_pkg;

    // Item kinds carried by the input channel.
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_TEMP_POINT = 2'd1;
    localparam logic [1:0] KIND_LAMBDA_POINT = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PUSHPULL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_PTS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA_PTS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd5;

    // Fixed-point constants.
    localparam logic [15:0] R17_Q20 = 16'd61681;
    localparam logic signed [20:0] VRP_Q16 = 21'sd29491;
    localparam logic [4:0] VRI_TWICE = 5'd31;
    localparam logic [13:0] CUR_SCALE = 14'd16000;
    localparam logic [4:0] GAIN_LOW = 5'd8;
    localparam logic [4:0] GAIN_HIGH = 5'd17;
    localparam int FRAC_BITS = 30;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         point_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [15:0]        vref_level;
        logic [15:0]        ur_level;
        logic [15:0]        ua_level;
        logic               amp_select;
        logic               force_req;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] cell_resistance;
        logic signed [31:0] temperature;
        logic signed [31:0] pump_current;
        logic signed [31:0] lambda_ratio;
        logic               calc_error;
    } out_item_t;

    // Request and response between the sequencer and the interpolation unit.
    typedef struct packed {
        logic               start;
        logic signed [31:0] x;
        logic [4:0]         npts;
    } interp_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] y;
    } interp_resp_t;

    // Signed result from a magnitude and a sign, clamped to 32 bits.
    function automatic logic [31:0] sat_mag(input logic neg, input logic [63:0] mag);
        logic [31:0] r;
        if (neg)
        begin
            r = (mag > 64'h8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
        end
        else
        begin
            r = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        end
        return r;
    endfunction

    // Full-scale value with the sign of the numerator, or zero when it is zero.
    function automatic logic [31:0] sat_sign(input logic pos, input logic neg);
        logic [31:0] r;
        r = pos ? 32'h7FFF_FFFF : (neg ? 32'h8000_0000 : 32'h0000_0000);
        return r;
    endfunction

endpackage

// ===== rtl/lambda_heater_sensor_convert_core.sv =====
// Top level of the wideband lambda sensor converter: sequencer, formulas and tables.
//
// Items enter on the sample channel (sample_valid / sample_stall) as in_item_t.
// A temperature or lambda point item is written into its table RAM at the edge
// it is accepted and yields no result. A sample item yields one result on the
// result channel (result_valid / result_stall) when enable is set or force_req
// is high; otherwise it is dropped. Point items and dropped samples leave no stall.
// Configuration registers are written on the cfg port, which is always ready;
// they should change only while the block is idle.
// A sample passes through two multiply states, then the resistance and the current
// divisions on one shared divider, then the two table lookups in turn. A lookup
// ends at the first or last point check when x lies at or past a table end;
// otherwise it scans for the segment and, when one holds x, adds a division and
// the multiply and sum steps of the interpolation. sample_stall is high from
// acceptance until the result is loaded, so samples are taken one at a time.
// A finished result waits in the output register while the receiver stalls; a
// further result is held back, with sample_stall high, until it is taken.
// Reset restores the configuration defaults and empties the output register;
// table contents are undefined until written.
module lambda_heater_sensor_convert_core #(
    parameter int TABLE_POINTS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  lhsc_pkg::in_item_t                   sample,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output lhsc_pkg::out_item_t                  result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lhsc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                          cfg_data
);
    import lhsc_pkg::*;

    localparam int AW = $clog2(TABLE_POINTS);

    typedef enum logic [3:0] {
        T_IDLE,
        T_MUL1,
        T_MUL2,
        T_DIVR,
        T_WAITR,
        T_DIVC,
        T_WAITC,
        T_INTT,
        T_WAITT,
        T_INTL,
        T_WAITL,
        T_OUT
    } state_t;

    state_t      state_reg;

    // Configuration registers.
    logic [31:0] pushpull_reg;
    logic [31:0] shunt_reg;
    logic [15:0] offset_reg;
    logic [4:0]  temp_pts_reg;
    logic [4:0]  lambda_pts_reg;
    logic        enable_reg;

    // Sample and intermediate registers.
    logic [15:0] vref_reg;
    logic [15:0] ur_reg;
    logic [15:0] ua_reg;
    logic        amp_reg;
    logic [31:0] vmul_reg;
    logic [31:0] vof_reg;
    logic [52:0] prodr_reg;
    logic [24:0] divr_reg;
    logic [45:0] curr_reg;
    logic [36:0] divc_reg;
    logic        d_pos_reg;
    logic        d_neg_reg;
    logic        e_pos_reg;
    logic        e_neg_reg;
    logic        h_pos_reg;
    logic        err_reg;
    logic [31:0] res_reg;
    logic [31:0] cur_reg;
    logic [31:0] temp_reg;
    logic [31:0] lam_reg;
    logic        result_valid_reg;
    out_item_t   result_reg;

    logic        accept;
    logic        starts_work;
    logic        out_free;
    logic        tbl_we_t;
    logic        tbl_we_l;
    logic [AW-1:0] wr_addr;
    logic [16:0] rnd17;
    logic signed [21:0] d_val;
    logic signed [20:0] h_val;
    logic [20:0] d_mag;
    logic signed [32:0] e_val;
    logic [31:0] e_mag;
    logic [4:0]  gain;
    logic        div_start;
    logic        div_busy;
    logic        div_done;
    logic [63:0] div_q;
    logic [63:0] div_dividend;
    logic [39:0] div_divisor;
    interp_req_t  ireq;
    interp_resp_t iresp;
    logic [AW-1:0] rd_addr;
    logic [63:0] rdata_t;
    logic [63:0] rdata_l;
    logic [63:0] rdata_sel;

    // Handshakes.
    assign sample_stall = (state_reg != T_IDLE);
    assign accept = sample_valid && !sample_stall;
    assign starts_work = (sample.kind == KIND_SAMPLE) && (enable_reg || sample.force_req);
    assign out_free = !result_valid_reg || !result_stall;
    assign cfg_ready = 1'b1;

    // Table point writes go straight into the RAMs; out-of-range indexes are dropped.
    assign wr_addr = AW'(sample.point_index);
    assign tbl_we_t = accept && (sample.kind == KIND_TEMP_POINT)
                      && (32'(sample.point_index) < TABLE_POINTS);
    assign tbl_we_l = accept && (sample.kind == KIND_LAMBDA_POINT)
                      && (32'(sample.point_index) < TABLE_POINTS);

    lhsc_ram #(
        .WIDTH(64),
        .DEPTH(TABLE_POINTS)
    ) u_temp_ram (
        .clk   (clk),
        .we    (tbl_we_t),
        .waddr (wr_addr),
        .wdata ({sample.point_x, sample.point_y}),
        .raddr (rd_addr),
        .rdata (rdata_t)
    );

    lhsc_ram #(
        .WIDTH(64),
        .DEPTH(TABLE_POINTS)
    ) u_lambda_ram (
        .clk   (clk),
        .we    (tbl_we_l),
        .waddr (wr_addr),
        .wdata ({sample.point_x, sample.point_y}),
        .raddr (rd_addr),
        .rdata (rdata_l)
    );

    assign rdata_sel = ((state_reg == T_INTL) || (state_reg == T_WAITL)) ? rdata_l : rdata_t;

    // Second multiply stage: offsets, magnitudes and the products fed to the divider.
    assign rnd17 = 17'((33'(vmul_reg) + 33'd32768) >> 16);
    assign d_val = $signed({2'b00, ur_reg, 4'b0000}) - $signed({5'b00000, rnd17});
    assign h_val = $signed({2'b00, vref_reg, 3'b000}) - VRP_Q16;
    assign d_mag = d_val[21] ? 21'(-d_val) : d_val[20:0];
    assign e_val = $signed({1'b0, ua_reg, 16'h0000}) - $signed({1'b0, vof_reg});
    assign e_mag = e_val[32] ? 32'(-e_val) : e_val[31:0];
    assign gain = amp_reg ? GAIN_LOW : GAIN_HIGH;

    // Shared divider for the resistance and current formulas.
    assign div_start = (state_reg == T_DIVR) || (state_reg == T_DIVC);
    assign div_dividend = (state_reg == T_DIVR) ? 64'(prodr_reg) : 64'(curr_reg);
    assign div_divisor = (state_reg == T_DIVR) ? 40'(divr_reg) : 40'(divc_reg);

    lhsc_div #(
        .DW(64),
        .VW(40)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // Interpolation requests.
    assign ireq.start = (state_reg == T_INTT) || (state_reg == T_INTL);
    assign ireq.x = (state_reg == T_INTL) ? cur_reg : res_reg;
    assign ireq.npts = (state_reg == T_INTL) ? lambda_pts_reg : temp_pts_reg;

    lhsc_interp #(
        .TABLE_POINTS(TABLE_POINTS)
    ) u_interp (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ireq),
        .resp    (iresp),
        .rd_addr (rd_addr),
        .rd_data (rdata_sel)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pushpull_reg <= 32'd65536;
            shunt_reg <= 32'd65536;
            offset_reg <= 16'd32768;
            temp_pts_reg <= 5'd2;
            lambda_pts_reg <= 5'd2;
            enable_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PUSHPULL:   pushpull_reg <= cfg_data;
                CFG_SHUNT:      shunt_reg <= cfg_data;
                CFG_OFFSET:     offset_reg <= cfg_data[15:0];
                CFG_TEMP_PTS:   temp_pts_reg <= cfg_data[4:0];
                CFG_LAMBDA_PTS: lambda_pts_reg <= cfg_data[4:0];
                CFG_ENABLE:     enable_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Sample sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == T_OUT) && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE:
                begin
                    if (accept && starts_work)
                    begin
                        vref_reg <= sample.vref_level;
                        ur_reg <= sample.ur_level;
                        ua_reg <= sample.ua_level;
                        amp_reg <= sample.amp_select;
                        state_reg <= T_MUL1;
                    end
                end
                T_MUL1:
                begin
                    vmul_reg <= vref_reg * R17_Q20;
                    vof_reg <= vref_reg * offset_reg;
                    state_reg <= T_MUL2;
                end
                T_MUL2:
                begin
                    prodr_reg <= d_mag * pushpull_reg;
                    divr_reg <= h_val[19:0] * VRI_TWICE;
                    curr_reg <= e_mag * CUR_SCALE;
                    divc_reg <= shunt_reg * gain;
                    d_pos_reg <= !d_val[21] && (d_val != 22'sd0);
                    d_neg_reg <= d_val[21];
                    e_pos_reg <= !e_val[32] && (e_val != 33'sd0);
                    e_neg_reg <= e_val[32];
                    h_pos_reg <= !h_val[20] && (h_val != 21'sd0);
                    err_reg <= h_val[20] || (h_val == 21'sd0) || (pushpull_reg == 32'd0)
                               || (shunt_reg == 32'd0);
                    state_reg <= T_DIVR;
                end
                T_DIVR:
                begin
                    state_reg <= T_WAITR;
                end
                T_WAITR:
                begin
                    if (div_done)
                    begin
                        res_reg <= h_pos_reg ? sat_mag(d_neg_reg, div_q)
                                             : sat_sign(d_pos_reg, d_neg_reg);
                        state_reg <= T_DIVC;
                    end
                end
                T_DIVC:
                begin
                    state_reg <= T_WAITC;
                end
                T_WAITC:
                begin
                    if (div_done)
                    begin
                        cur_reg <= (shunt_reg != 32'd0) ? sat_mag(e_neg_reg, div_q)
                                                        : sat_sign(e_pos_reg, e_neg_reg);
                        state_reg <= T_INTT;
                    end
                end
                T_INTT:
                begin
                    state_reg <= T_WAITT;
                end
                T_WAITT:
                begin
                    if (iresp.done)
                    begin
                        temp_reg <= iresp.y;
                        state_reg <= T_INTL;
                    end
                end
                T_INTL:
                begin
                    state_reg <= T_WAITL;
                end
                T_WAITL:
                begin
                    if (iresp.done)
                    begin
                        lam_reg <= iresp.y;
                        state_reg <= T_OUT;
                    end
                end
                T_OUT:
                begin
                    if (out_free)
                    begin
                        result_reg.cell_resistance <= res_reg;
                        result_reg.temperature <= temp_reg;
                        result_reg.pump_current <= cur_reg;
                        result_reg.lambda_ratio <= lam_reg;
                        result_reg.calc_error <= err_reg;
                        state_reg <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result = result_reg;

    // An item that produces no result leaves the block ready for the next one.
    a_no_work: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !starts_work) |=> !sample_stall)
        else $error("item without result left the block busy");

    // The shared divider is only started when it is free.
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("formula divider started while busy");

    // A finished result is always loaded into a free output register.
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_OUT && out_free) |=> result_valid_reg)
        else $error("result not presented after completion");

    // A result that was taken and not replaced leaves the output empty.
    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_stall && state_reg != T_OUT) |=> !result_valid_reg)
        else $error("result repeated after it was taken");

endmodule

// ===== rtl/lhsc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module lhsc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lhsc_div.sv =====
// Iterative unsigned restoring divider, one quotient bit per cycle.
module lhsc_div #(
    parameter int DW = 64,
    parameter int VW = 40
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [VW:0]   rem_sh;
    logic          fits;

    // Shift in the next dividend bit and try a subtraction.
    assign rem_sh = {rem_reg, quo_reg[DW-1]};
    assign fits = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= VW'(rem_sh - {1'b0, dvs_reg});
            end
            else
            begin
                rem_reg <= rem_sh[VW-1:0];
            end
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/lhsc_interp.sv =====
// Piecewise-linear table lookup: breakpoint search over a RAM and one interpolation.
module lhsc_interp #(
    parameter int TABLE_POINTS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lhsc_pkg::interp_req_t           req,
    output lhsc_pkg::interp_resp_t          resp,
    output logic [$clog2(TABLE_POINTS)-1:0] rd_addr,
    input  logic [63:0]                     rd_data
);
    import lhsc_pkg::*;

    localparam int AW = $clog2(TABLE_POINTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_SCAN,
        S_DIV,
        S_MUL,
        S_FIN
    } state_t;

    state_t             state_reg;
    logic [AW-1:0]      last_reg;
    logic [AW-1:0]      j_reg;
    logic signed [31:0] x_reg;
    logic signed [31:0] prev_x_reg;
    logic signed [31:0] prev_y_reg;
    logic signed [31:0] ylast_reg;
    logic signed [32:0] dy_reg;
    logic [29:0]        f_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] y_reg;
    logic               done_reg;

    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic               hit;
    logic [32:0]        t_val;
    logic [32:0]        dx_val;
    logic               div_start;
    logic               div_busy;
    logic               div_done;
    logic [63:0]        div_q;
    logic [63:0]        prod_mag;
    logic [33:0]        q_mag;
    logic signed [33:0] y_sum;
    logic [AW:0]        npts_clamped;

    assign cur_x = rd_data[63:32];
    assign cur_y = rd_data[31:0];

    // Point count clamped to one through the table depth.
    always_comb
    begin
        if (req.npts == 5'd0)
        begin
            npts_clamped = (AW + 1)'(1);
        end
        else if (32'(req.npts) > TABLE_POINTS)
        begin
            npts_clamped = (AW + 1)'(TABLE_POINTS);
        end
        else
        begin
            npts_clamped = (AW + 1)'(req.npts);
        end
    end

    // Segment test and interpolation operands.
    assign hit = (prev_x_reg <= x_reg) && (x_reg < cur_x);
    assign t_val = 33'($signed({x_reg[31], x_reg}) - $signed({prev_x_reg[31], prev_x_reg}));
    assign dx_val = 33'($signed({cur_x[31], cur_x}) - $signed({prev_x_reg[31], prev_x_reg}));
    assign div_start = (state_reg == S_SCAN) && hit;

    lhsc_div #(
        .DW(64),
        .VW(33)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({1'b0, t_val, 30'd0}),
        .divisor  (dx_val),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // Product scaled back by 2^30, truncated toward zero.
    assign prod_mag = prod_reg[63] ? 64'(-prod_reg) : prod_reg;
    assign q_mag = 34'(prod_mag >> FRAC_BITS);
    assign y_sum = $signed({{2{prev_y_reg[31]}}, prev_y_reg})
                   + (prod_reg[63] ? -$signed(q_mag) : $signed(q_mag));

    // Read address for the entry that the next state examines.
    always_comb
    begin
        case (state_reg)
            S_IDLE:  rd_addr = '0;
            S_FIRST: rd_addr = last_reg;
            S_LAST:  rd_addr = AW'(1);
            S_SCAN:  rd_addr = j_reg + 1'b1;
            default: rd_addr = '0;
        endcase
    end

    // Search and interpolation sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        x_reg <= req.x;
                        last_reg <= AW'(npts_clamped - 1'b1);
                        state_reg <= S_FIRST;
                    end
                end
                S_FIRST:
                begin
                    prev_x_reg <= cur_x;
                    prev_y_reg <= cur_y;
                    if (x_reg <= cur_x)
                    begin
                        y_reg <= cur_y;
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_LAST;
                    end
                end
                S_LAST:
                begin
                    ylast_reg <= cur_y;
                    j_reg <= AW'(1);
                    if (x_reg >= cur_x)
                    begin
                        y_reg <= cur_y;
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (hit)
                    begin
                        dy_reg <= $signed({cur_y[31], cur_y}) - $signed({prev_y_reg[31], prev_y_reg});
                        state_reg <= S_DIV;
                    end
                    else if (j_reg == last_reg)
                    begin
                        y_reg <= ylast_reg;
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        prev_x_reg <= cur_x;
                        prev_y_reg <= cur_y;
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        f_reg <= div_q[29:0];
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg <= 64'(dy_reg * $signed({1'b0, f_reg}));
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    y_reg <= y_sum[31:0];
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign resp.done = done_reg;
    assign resp.y = y_reg;

    // The divider is only started when it is free.
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("interpolation divider started while busy");

    // A finished quotient arrives only while waiting for it.
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("interpolation quotient arrived outside the wait state");

    // The done pulse of a lookup comes only once the sequencer is back in idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("interpolation done pulse outside idle");

endmodule

// ===== tb/sv/lambda_heater_sensor_convert_core_checker.sv =====
// Checker for the lambda sensor converter: watches the channels, predicts results and compares.
`timescale 1ns / 100ps

module lambda_heater_sensor_convert_core_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    input  logic                           sample_stall,
    input  lhsc_pkg::in_item_t             sample,
    input  logic                           result_valid,
    input  logic                           result_stall,
    input  lhsc_pkg::out_item_t            result,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [lhsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    output int                             fail_count,
    output int                             pending
);
    import lhsc_pkg::*;

    localparam int NPTS = 16;

    // Local copy of the configuration registers.
    logic [31:0] pp_ohms;
    logic [31:0] shunt_ohms;
    logic [15:0] ua_offset;
    logic [4:0]  temp_npts;
    logic [4:0]  lambda_npts;
    logic        conv_enable;

    // Local copy of the breakpoint tables.
    logic signed [31:0] temp_x [NPTS];
    logic signed [31:0] temp_y [NPTS];
    logic signed [31:0] lam_x [NPTS];
    logic signed [31:0] lam_y [NPTS];

    out_item_t expected_results [$];

    assign pending = expected_results.size();

    // Clamp a wide value to the signed 32-bit range.
    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Full scale carrying the sign of v, or zero.
    function automatic longint full_scale(input longint v);
        if (v > 0)
            return 64'sd2147483647;
        if (v < 0)
            return -64'sd2147483648;
        return 64'sd0;
    endfunction

    // Piecewise-linear lookup; lam selects the lambda table.
    function automatic longint lookup(input bit lam, input logic [4:0] npts, input longint x);
        longint xs [NPTS];
        longint ys [NPTS];
        int n;
        longint unsigned t;
        longint unsigned dx;
        longint f;
        longint dy;
        for (int k = 0; k < NPTS; k++)
        begin
            xs[k] = lam ? longint'(lam_x[k]) : longint'(temp_x[k]);
            ys[k] = lam ? longint'(lam_y[k]) : longint'(temp_y[k]);
        end
        n = int'(npts);
        if (n < 1)
            n = 1;
        if (n > NPTS)
            n = NPTS;
        if (x <= xs[0])
            return ys[0];
        if (x >= xs[n-1])
            return ys[n-1];
        for (int i = 0; i + 1 < n; i++)
        begin
            if (xs[i] <= x && x < xs[i+1])
            begin
                t = longint'(x - xs[i]);
                dx = longint'(xs[i+1] - xs[i]);
                f = longint'((t << FRAC_BITS) / dx);
                dy = ys[i+1] - ys[i];
                return ys[i] + (dy * f) / (64'sd1 <<< FRAC_BITS);
            end
        end
        // No segment holds x when the breakpoints are out of order.
        return ys[n-1];
    endfunction

    // Works out the conversion result of one sample item.
    function automatic out_item_t convert_sample(input in_item_t s);
        out_item_t r;
        longint vref;
        longint ur;
        longint ua;
        longint d;
        longint h;
        longint e;
        longint gain;
        longint res;
        longint cur;
        longint temp_val;
        longint lam_val;
        bit err;
        err = 1'b0;
        vref = longint'(s.vref_level);
        ur = longint'(s.ur_level);
        ua = longint'(s.ua_level);
        gain = s.amp_select ? longint'(GAIN_LOW) : longint'(GAIN_HIGH);

        // Cell resistance; a reference at or below 0.9 V saturates.
        d = (ur << 4) - ((vref * longint'(R17_Q20) + 32768) >>> 16);
        h = (vref << 3) - longint'(VRP_Q16);
        if (h <= 0)
        begin
            err = 1'b1;
            res = full_scale(d);
        end
        else
        begin
            if (pp_ohms == 0)
                err = 1'b1;
            res = clamp32((d * longint'(pp_ohms)) / (longint'(VRI_TWICE) * h));
        end

        // Pump current; a zero shunt saturates.
        e = (ua << 16) - vref * longint'(ua_offset);
        if (shunt_ohms == 0)
        begin
            err = 1'b1;
            cur = full_scale(e);
        end
        else
        begin
            cur = clamp32((e * longint'(CUR_SCALE)) / (longint'(shunt_ohms) * gain));
        end

        temp_val = lookup(1'b0, temp_npts, res);
        lam_val = lookup(1'b1, lambda_npts, cur);
        r.cell_resistance = res[31:0];
        r.temperature = temp_val[31:0];
        r.pump_current = cur[31:0];
        r.lambda_ratio = lam_val[31:0];
        r.calc_error = err;
        return r;
    endfunction

    // Report one mismatching result item, expected value first.
    task automatic report_mismatch(input out_item_t want, input out_item_t got);
        $display("Mismatch exp/act: res %0d/%0d temp %0d/%0d cur %0d/%0d lam %0d/%0d err %0b/%0b",
                 want.cell_resistance, got.cell_resistance,
                 want.temperature, got.temperature,
                 want.pump_current, got.pump_current,
                 want.lambda_ratio, got.lambda_ratio,
                 want.calc_error, got.calc_error);
    endtask

    // Track configuration, tables and expectations; compare results.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            pp_ohms <= 32'd65536;
            shunt_ohms <= 32'd65536;
            ua_offset <= 16'd32768;
            temp_npts <= 5'd2;
            lambda_npts <= 5'd2;
            conv_enable <= 1'b0;
            fail_count <= 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PUSHPULL:   pp_ohms <= cfg_data;
                    CFG_SHUNT:      shunt_ohms <= cfg_data;
                    CFG_OFFSET:     ua_offset <= cfg_data[15:0];
                    CFG_TEMP_PTS:   temp_npts <= cfg_data[4:0];
                    CFG_LAMBDA_PTS: lambda_npts <= cfg_data[4:0];
                    CFG_ENABLE:     conv_enable <= cfg_data[0];
                    default:        ;
                endcase
            end

            if (sample_valid && !sample_stall)
            begin
                if (sample.kind == KIND_TEMP_POINT)
                begin
                    temp_x[sample.point_index] <= sample.point_x;
                    temp_y[sample.point_index] <= sample.point_y;
                end
                else if (sample.kind == KIND_LAMBDA_POINT)
                begin
                    lam_x[sample.point_index] <= sample.point_x;
                    lam_y[sample.point_index] <= sample.point_y;
                end
                else if (sample.kind == KIND_SAMPLE && (conv_enable || sample.force_req))
                begin
                    expected_results.push_back(convert_sample(sample));
                end
            end

            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("Unexpected result item: %h", result);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.cell_resistance !== want.cell_resistance ||
                        result.temperature !== want.temperature ||
                        result.pump_current !== want.pump_current ||
                        result.lambda_ratio !== want.lambda_ratio ||
                        result.calc_error !== want.calc_error)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            report_mismatch(want, result);
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/lambda_heater_sensor_convert_core_test.sv =====
// Top of the lambda sensor converter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module lambda_heater_sensor_convert_core_test;
    import lhsc_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 400;
    localparam int PHASES = 9;
    localparam int ITEMS_PER_PHASE = 130;

    logic                 clk;
    logic                 rst_n;
    logic                 sample_valid;
    logic                 sample_stall;
    in_item_t             sample;
    logic                 result_valid;
    logic                 result_stall;
    out_item_t            result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    int                   fail_count;
    int                   pending;
    int                   cycles;
    bit                   quiet;
    int                   stall_burst;

    lambda_heater_sensor_convert_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample(sample),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    lambda_heater_sensor_convert_core_checker checker_inst (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample(sample),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .fail_count(fail_count),
        .pending(pending)
    );

    // 12 ns clock.
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Cycle counter guarding against a hang.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver stalls in short random bursts, none in the quiet part.
    always @(negedge clk)
    begin
        if (!rst_n || quiet)
        begin
            result_stall <= 1'b0;
            stall_burst <= 0;
        end
        else if (stall_burst > 0)
        begin
            result_stall <= 1'b1;
            stall_burst <= stall_burst - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            result_stall <= 1'b1;
            stall_burst <= $urandom_range(0, 2);
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // Offer one item, with an optional idle burst first; returns at a falling edge.
    task automatic send_item(input in_item_t it);
        int gap;
        gap = (quiet || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 3);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample <= it;
        sample_valid <= 1'b1;
        do
            @(posedge clk);
        while (sample_stall);
        @(negedge clk);
    endtask

    // Drop the sample valid and wait until nothing is left in flight.
    task automatic wait_idle;
        sample_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_settings(input logic [31:0] pp, input logic [31:0] sh,
                                  input logic [15:0] off, input logic [4:0] tp,
                                  input logic [4:0] lp, input logic en);
        write_reg(CFG_PUSHPULL, pp);
        write_reg(CFG_SHUNT, sh);
        write_reg(CFG_OFFSET, {16'd0, off});
        write_reg(CFG_TEMP_PTS, {27'd0, tp});
        write_reg(CFG_LAMBDA_PTS, {27'd0, lp});
        write_reg(CFG_ENABLE, {31'd0, en});
    endtask

    function automatic in_item_t point_item(input logic [1:0] kind, input logic [3:0] idx,
                                            input logic [31:0] px, input logic [31:0] py);
        in_item_t it;
        it = '0;
        it.kind = kind;
        it.point_index = idx;
        it.point_x = px;
        it.point_y = py;
        it.vref_level = 16'($urandom);
        it.ur_level = 16'($urandom);
        it.ua_level = 16'($urandom);
        it.amp_select = 1'($urandom);
        it.force_req = 1'($urandom);
        return it;
    endfunction

    function automatic in_item_t sample_item(input logic [15:0] vref, input logic [15:0] ur,
                                             input logic [15:0] ua, input logic amp,
                                             input logic frc);
        in_item_t it;
        it = '0;
        it.kind = KIND_SAMPLE;
        it.point_index = 4'($urandom);
        it.point_x = $urandom;
        it.point_y = $urandom;
        it.vref_level = vref;
        it.ur_level = ur;
        it.ua_level = ua;
        it.amp_select = amp;
        it.force_req = frc;
        return it;
    endfunction

    // Breakpoint value: mostly near the working range, sometimes full scale.
    function automatic int point_value();
        if ($urandom_range(0, 2) == 0)
            return int'($urandom);
        return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endfunction

    // Rewrite all points of both tables; ascending unless asked otherwise.
    task automatic load_tables(input bit ascending);
        int xs [$];
        for (int t = 0; t < 2; t++)
        begin
            xs.delete();
            for (int i = 0; i < 16; i++)
                xs.push_back(point_value());
            if (ascending)
                xs.sort();
            for (int i = 0; i < 16; i++)
                send_item(point_item(t ? KIND_LAMBDA_POINT : KIND_TEMP_POINT, i[3:0],
                                     xs[i], $urandom));
        end
    endtask

    // Random item: mostly well-formed samples, some table rewrites and ignored kinds.
    function automatic in_item_t random_item();
        int sel;
        logic [15:0] vref;
        sel = $urandom_range(0, 99);
        if (sel < 3)
            return point_item(2'($urandom_range(1, 2)), 4'($urandom), point_value(), $urandom);
        if (sel < 5)
            return point_item(2'd3, 4'($urandom), $urandom, $urandom);
        case ($urandom_range(0, 3))
            0:       vref = 16'($urandom);
            1:       vref = 16'($urandom_range(3600, 3800));
            default: vref = 16'($urandom_range(16384, 24576));
        endcase
        return sample_item(vref,
                           16'(($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 4096)),
                           16'($urandom), 1'($urandom), ($urandom_range(0, 4) == 0));
    endfunction

    initial
    begin
        in_item_t directed [$];
        logic [4:0] tp;
        logic [4:0] lp;
        cycles = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        result_stall = 1'b0;
        stall_burst = 0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Every breakpoint is written before any sample can read it.
        load_tables(1'b1);

        // Directed samples at reset settings: field extremes and the reference threshold.
        directed.push_back(sample_item(16'd0, 16'd0, 16'd0, 1'b0, 1'b1));
        directed.push_back(sample_item(16'd0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
        directed.push_back(sample_item(16'hFFFF, 16'd0, 16'd0, 1'b0, 1'b1));
        directed.push_back(sample_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
        directed.push_back(sample_item(16'd3686, 16'd100, 16'd2000, 1'b0, 1'b1));
        directed.push_back(sample_item(16'd3687, 16'd100, 16'd2000, 1'b1, 1'b1));
        directed.push_back(sample_item(16'd3686, 16'd0, 16'd0, 1'b0, 1'b1));
        directed.push_back(sample_item(16'd20480, 16'd1200, 16'd10240, 1'b0, 1'b1));
        directed.push_back(sample_item(16'd20480, 16'd1200, 16'd10240, 1'b1, 1'b0));
        directed.push_back(point_item(2'd3, 4'd15, 32'h7FFF_FFFF, 32'h8000_0000));
        foreach (directed[i])
            send_item(directed[i]);

        // Phases of settings, extremes first, then random.
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            tp = 5'($urandom_range(0, 31));
            lp = 5'($urandom_range(0, 31));
            case (p)
                0: write_settings(32'd0, 32'd0, 16'd0, 5'd0, 5'd1, 1'b1);
                1: write_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 5'd31, 5'd16, 1'b1);
                2: write_settings(32'd1, 32'd1, 16'd0, 5'd16, 5'd16, 1'b0);
                3: write_settings(32'd65536 * 500, 32'd65536 * 62, 16'($urandom), 5'd16, 5'd2,
                                  1'b1);
                default: write_settings(($urandom_range(0, 1) == 0) ? $urandom
                                                                   : $urandom_range(1, 32'h0800_0000),
                                        ($urandom_range(0, 1) == 0) ? $urandom
                                                                   : $urandom_range(1, 32'h0080_0000),
                                        16'($urandom), tp, lp, ($urandom_range(0, 3) != 0));
            endcase
            if (p == 5)
                load_tables(1'b0);
            else if (p % 3 == 2)
                load_tables(1'b1);
            if (p == PHASES - 1)
                quiet = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                send_item(random_item());
        end

        wait_idle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
